// ----- rtl/core/rpi_pkg.sv -----
// shared types, constants and saturating fixed-point helpers for the
// ray / paraboloid intersection core; no dependencies
package rpi_pkg;

   localparam int DATA_W        = 32;
   localparam int DEN_W         = 33;
   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_IDX_W     = 3;

   localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] REG_CENTER_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEMI_A     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SEMI_B     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SEMI_C     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HYPERBOLIC = 3'd6;

   localparam logic [1:0] ST_TWO    = 2'd0;
   localparam logic [1:0] ST_LINEAR = 2'd1;
   localparam logic [1:0] ST_NONE   = 2'd2;
   localparam logic [1:0] ST_DEGEN  = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] cx;
      logic signed [DATA_W-1:0] cy;
      logic signed [DATA_W-1:0] cz;
      logic [DATA_W-2:0]        sa;
      logic [DATA_W-2:0]        sb;
      logic [DATA_W-2:0]        sc;
      logic                     hyp;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [DATA_W-1:0] c;
      logic [1:0]               kind;
   } coef_type;

   function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
      logic same;
      same = (&v[63:DATA_W-1]) || !(|v[63:DATA_W-1]);
      if (same) return v[DATA_W-1:0];
      return v[63] ? Q_MIN : Q_MAX;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] == s[DATA_W-1]) return s[DATA_W-1:0];
      return s[DATA_W] ? Q_MIN : Q_MAX;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (s[DATA_W] == s[DATA_W-1]) return s[DATA_W-1:0];
      return s[DATA_W] ? Q_MIN : Q_MAX;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_neg(input logic signed [DATA_W-1:0] a);
      return sat_sub('0, a);
   endfunction

   function automatic logic signed [DATA_W-1:0] zsign(input logic hyp,
                                                      input logic signed [DATA_W-1:0] a);
      return hyp ? sat_neg(a) : a;
   endfunction

   // product shifted right with floor rounding, then saturated
   function automatic logic signed [DATA_W-1:0] qmul(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b,
                                                     input int frac);
      logic signed [63:0] p;
      p = a * b;
      return sat64(p >>> frac);
   endfunction

endpackage

// ----- rtl/core/rpi_div.sv -----
// pipelined signed fixed-point divider, one quotient bit per stage
// depends on rpi_pkg
module rpi_div import rpi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SW        = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic signed [DATA_W-1:0] num,
   input  logic signed [DEN_W-1:0]  den,
   input  logic [SW-1:0]            sb_in,
   output logic signed [DATA_W-1:0] quo,
   output logic [SW-1:0]            sb_out
);
   localparam int QW = DATA_W + FRAC_BITS;
   localparam int RW = DEN_W + 1;

   logic [QW-1:0]    n_ff   [QW+1];
   logic [QW-1:0]    q_ff   [QW+1];
   logic [RW-1:0]    r_ff   [QW+1];
   logic [DEN_W-1:0] d_ff   [QW+1];
   logic             neg_ff [QW+1];
   logic [SW-1:0]    sb_ff  [QW+1];
   logic [QW-1:0]    n_in   [QW];
   logic [QW-1:0]    q_in   [QW];
   logic [RW-1:0]    r_in   [QW];
   logic [DATA_W:0]  num_x, num_m;
   logic [DEN_W:0]   den_x, den_m;
   logic [RW-1:0]    shifted;
   logic [QW-1:0]    qf;
   logic             big;
   logic signed [DATA_W-1:0] quo_in;

   always_comb begin
      num_x = {num[DATA_W-1], num};
      num_m = num_x[DATA_W] ? -num_x : num_x;
      den_x = {den[DEN_W-1], den};
      den_m = den_x[DEN_W] ? -den_x : den_x;
      for (int k = 0; k < QW; k++) begin
         shifted = {r_ff[k][RW-2:0], n_ff[k][QW-1]};
         n_in[k] = n_ff[k] << 1;
         if (shifted >= {1'b0, d_ff[k]}) begin
            r_in[k] = shifted - {1'b0, d_ff[k]};
            q_in[k] = {q_ff[k][QW-2:0], 1'b1};
         end else begin
            r_in[k] = shifted;
            q_in[k] = {q_ff[k][QW-2:0], 1'b0};
         end
      end
      qf  = q_ff[QW];
      big = |qf[QW-1:DATA_W-1];
      if (neg_ff[QW]) begin
         quo_in = big ? Q_MIN : -qf[DATA_W-1:0];
      end else begin
         quo_in = big ? Q_MAX : qf[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) sb_ff[k] <= '0;
         sb_out <= '0;
      end else if (en) begin
         sb_ff[0] <= sb_in;
         for (int k = 0; k < QW; k++) sb_ff[k+1] <= sb_ff[k];
         sb_out <= sb_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0]   <= {num_m[DATA_W-1:0], {FRAC_BITS{1'b0}}};
         q_ff[0]   <= '0;
         r_ff[0]   <= '0;
         d_ff[0]   <= den_m[DEN_W-1:0];
         neg_ff[0] <= num[DATA_W-1] ^ den[DEN_W-1];
         for (int k = 0; k < QW; k++) begin
            n_ff[k+1]   <= n_in[k];
            q_ff[k+1]   <= q_in[k];
            r_ff[k+1]   <= r_in[k];
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
         quo <= quo_in;
      end
   end

endmodule

// ----- rtl/core/rpi_sqrt.sv -----
// pipelined integer square root of rad shifted up by the fraction bits,
// one root bit per stage; depends on rpi_pkg
module rpi_sqrt import rpi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int SW        = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [DATA_W-2:0] rad,
   input  logic [SW-1:0]     sb_in,
   output logic [DATA_W-1:0] root,
   output logic [SW-1:0]     sb_out
);
   localparam int SQ = (DATA_W + FRAC_BITS) / 2;
   localparam int VW = 2 * SQ;

   logic [VW-1:0] v_ff  [SQ+1];
   logic [SQ+1:0] r_ff  [SQ+1];
   logic [SQ-1:0] q_ff  [SQ+1];
   logic [SW-1:0] sb_ff [SQ+1];
   logic [VW-1:0] v_in  [SQ];
   logic [SQ+1:0] r_in  [SQ];
   logic [SQ-1:0] q_in  [SQ];
   logic [SQ+1:0] rs, trial;

   always_comb begin
      for (int k = 0; k < SQ; k++) begin
         rs      = {r_ff[k][SQ-1:0], v_ff[k][VW-1 -: 2]};
         trial   = {q_ff[k], 2'b01};
         v_in[k] = v_ff[k] << 2;
         if (rs >= trial) begin
            r_in[k] = rs - trial;
            q_in[k] = {q_ff[k][SQ-2:0], 1'b1};
         end else begin
            r_in[k] = rs;
            q_in[k] = {q_ff[k][SQ-2:0], 1'b0};
         end
      end
   end

   assign root   = DATA_W'(q_ff[SQ]);
   assign sb_out = sb_ff[SQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ; k++) sb_ff[k] <= '0;
      end else if (en) begin
         sb_ff[0] <= sb_in;
         for (int k = 0; k < SQ; k++) sb_ff[k+1] <= sb_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0] <= VW'(rad) << FRAC_BITS;
         r_ff[0] <= '0;
         q_ff[0] <= '0;
         for (int k = 0; k < SQ; k++) begin
            v_ff[k+1] <= v_in[k];
            r_ff[k+1] <= r_in[k];
            q_ff[k+1] <= q_in[k];
         end
      end
   end

endmodule

// ----- rtl/core/rpi_front.sv -----
// front end: accepts rays, forms the quadratic coefficients and classifies
// them; depends on rpi_pkg and rpi_div
module rpi_front import rpi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] origin_x,
   input  logic signed [DATA_W-1:0] origin_y,
   input  logic signed [DATA_W-1:0] origin_z,
   input  logic signed [DATA_W-1:0] dir_x,
   input  logic signed [DATA_W-1:0] dir_y,
   input  logic signed [DATA_W-1:0] dir_z,
   output logic                     push_valid,
   output coef_type                 push_data,
   input  logic                     queue_full
);
   logic efront;
   logic v1_ff;
   logic signed [DATA_W-1:0] dx1_ff, dy1_ff, dz1_ff, px1_ff, pz1_ff, cy1_ff;
   logic signed [DATA_W-1:0] px1_in, pz1_in, cy1_in;
   logic signed [DATA_W-1:0] dxa, dzc, pxa, pzc, hyb, cyb;
   logic [5:0] vd;
   logic signed [DEN_W-1:0] den_a, den_b, den_2b, den_c;
   logic vm1_ff, vm2_ff, v3_ff;
   logic signed [DATA_W-1:0] aa_ff, ac_ff, ba_ff, bc_ff, ca_ff, cc_ff, hy1_ff, cyb1_ff;
   logic signed [DATA_W-1:0] a2_ff, bp2_ff, cp2_ff, hy2_ff, cyb2_ff;
   logic signed [DATA_W-1:0] a2_in, bp2_in, cp2_in, b3_in, c3_in;
   logic [1:0] kind3_in;
   coef_type coef3_ff;

   assign efront     = !v3_ff || !queue_full;
   assign req_ready  = efront;
   assign push_valid = v3_ff;
   assign push_data  = coef3_ff;

   assign px1_in = sat_sub(origin_x, cfg.cx);
   assign pz1_in = sat_sub(origin_z, cfg.cz);
   assign cy1_in = sat_sub(cfg.cy, origin_y);

   assign den_a  = {2'b00, cfg.sa};
   assign den_b  = {2'b00, cfg.sb};
   assign den_2b = {1'b0, cfg.sb, 1'b0};
   assign den_c  = {2'b00, cfg.sc};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         vm1_ff <= 1'b0;
         vm2_ff <= 1'b0;
         v3_ff  <= 1'b0;
      end else if (efront) begin
         v1_ff  <= req_valid;
         vm1_ff <= &vd;
         vm2_ff <= vm1_ff;
         v3_ff  <= vm2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (efront) begin
         dx1_ff <= dir_x;
         dy1_ff <= dir_y;
         dz1_ff <= dir_z;
         px1_ff <= px1_in;
         pz1_ff <= pz1_in;
         cy1_ff <= cy1_in;
      end
   end

   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_dxa (
      .clock, .reset, .en(efront), .num(dx1_ff), .den(den_a),
      .sb_in(v1_ff), .quo(dxa), .sb_out(vd[0]));
   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_dzc (
      .clock, .reset, .en(efront), .num(dz1_ff), .den(den_c),
      .sb_in(v1_ff), .quo(dzc), .sb_out(vd[1]));
   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_pxa (
      .clock, .reset, .en(efront), .num(px1_ff), .den(den_a),
      .sb_in(v1_ff), .quo(pxa), .sb_out(vd[2]));
   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_pzc (
      .clock, .reset, .en(efront), .num(pz1_ff), .den(den_c),
      .sb_in(v1_ff), .quo(pzc), .sb_out(vd[3]));
   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_hyb (
      .clock, .reset, .en(efront), .num(dy1_ff), .den(den_2b),
      .sb_in(v1_ff), .quo(hyb), .sb_out(vd[4]));
   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_cyb (
      .clock, .reset, .en(efront), .num(cy1_ff), .den(den_b),
      .sb_in(v1_ff), .quo(cyb), .sb_out(vd[5]));

   always_ff @(posedge clock) begin
      if (efront) begin
         aa_ff   <= qmul(dxa, dxa, FRAC_BITS);
         ac_ff   <= qmul(dzc, dzc, FRAC_BITS);
         ba_ff   <= qmul(sat_neg(pxa), dxa, FRAC_BITS);
         bc_ff   <= qmul(sat_neg(pzc), dzc, FRAC_BITS);
         ca_ff   <= qmul(pxa, pxa, FRAC_BITS);
         cc_ff   <= qmul(pzc, pzc, FRAC_BITS);
         hy1_ff  <= hyb;
         cyb1_ff <= cyb;
      end
   end

   assign a2_in  = sat_add(aa_ff, zsign(cfg.hyp, ac_ff));
   assign bp2_in = sat_add(ba_ff, zsign(cfg.hyp, bc_ff));
   assign cp2_in = sat_add(ca_ff, zsign(cfg.hyp, cc_ff));

   always_ff @(posedge clock) begin
      if (efront) begin
         a2_ff   <= a2_in;
         bp2_ff  <= bp2_in;
         cp2_ff  <= cp2_in;
         hy2_ff  <= hy1_ff;
         cyb2_ff <= cyb1_ff;
      end
   end

   assign b3_in = sat_add(bp2_ff, hy2_ff);
   assign c3_in = sat_add(cp2_ff, cyb2_ff);

   always_comb begin
      priority if (cfg.sa == '0 || cfg.sb == '0 || cfg.sc == '0) begin
         kind3_in = ST_DEGEN;
      end else if (a2_ff == '0) begin
         kind3_in = (b3_in == '0) ? ST_DEGEN : ST_LINEAR;
      end else begin
         kind3_in = ST_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (efront) begin
         coef3_ff.a    <= a2_ff;
         coef3_ff.b    <= b3_in;
         coef3_ff.c    <= c3_in;
         coef3_ff.kind <= kind3_in;
      end
   end

endmodule

// ----- rtl/core/rpi_queue.sv -----
// short coefficient queue between front and back end
// depends on rpi_pkg
module rpi_queue import rpi_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  coef_type push_data,
   output logic     full,
   output logic     pop_valid,
   output coef_type pop_data,
   input  logic     pop_ready
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   coef_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == (PW+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- rtl/core/rpi_back.sv -----
// back end: discriminant, square root and root division, result register
// depends on rpi_pkg, rpi_sqrt and rpi_div
module rpi_back import rpi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   input  coef_type                 pop_data,
   output logic                     pop_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] t_near,
   output logic signed [DATA_W-1:0] t_far,
   output logic                     hit,
   output logic [1:0]               root_status
);
   localparam int SSW = 2 + $bits(coef_type);

   logic eback;
   logic vb1_ff, vb2_ff, vb3_ff, vb4_ff;
   coef_type c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [DATA_W-1:0] bb2_ff, ac2_ff, delta3_ff, delta3_in;
   logic neg3_ff, neg4_ff;
   logic [SSW-1:0] sq_sb_out;
   logic [DATA_W-1:0] root;
   logic signed [DATA_W-1:0] nm4_ff, np4_ff, nm4_in, np4_in;
   logic signed [DATA_W-1:0] t1, t2, tl;
   logic [3:0] d1_sb;
   logic d2_v, d3_v;
   logic out_v;
   logic rsp_valid_ff;
   logic signed [DATA_W-1:0] t_near_ff, t_far_ff, t_near_in, t_far_in;
   logic hit_ff, hit_in;
   logic [1:0] status_ff, status_in;

   assign eback     = !rsp_valid_ff || rsp_ready;
   assign pop_ready = eback;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb1_ff <= 1'b0;
         vb2_ff <= 1'b0;
         vb3_ff <= 1'b0;
         vb4_ff <= 1'b0;
      end else if (eback) begin
         vb1_ff <= pop_valid;
         vb2_ff <= vb1_ff;
         vb3_ff <= vb2_ff;
         vb4_ff <= sq_sb_out[SSW-1];
      end
   end

   assign delta3_in = sat_sub(bb2_ff, ac2_ff);

   always_ff @(posedge clock) begin
      if (eback) begin
         c1_ff     <= pop_data;
         c2_ff     <= c1_ff;
         bb2_ff    <= qmul(c1_ff.b, c1_ff.b, FRAC_BITS);
         ac2_ff    <= qmul(c1_ff.a, c1_ff.c, FRAC_BITS);
         c3_ff     <= c2_ff;
         delta3_ff <= delta3_in;
         neg3_ff   <= delta3_in[DATA_W-1];
      end
   end

   rpi_sqrt #(.FRAC_BITS(FRAC_BITS), .SW(SSW)) u_sqrt (
      .clock, .reset, .en(eback),
      .rad(neg3_ff ? '0 : delta3_ff[DATA_W-2:0]),
      .sb_in({vb3_ff, neg3_ff, c3_ff}),
      .root, .sb_out(sq_sb_out));

   assign nm4_in = sat_sub(sq_sb_out[DATA_W+2 +: DATA_W], $signed(root));
   assign np4_in = sat_add(sq_sb_out[DATA_W+2 +: DATA_W], $signed(root));

   always_ff @(posedge clock) begin
      if (eback) begin
         c4_ff   <= sq_sb_out[$bits(coef_type)-1:0];
         neg4_ff <= sq_sb_out[SSW-2];
         nm4_ff  <= nm4_in;
         np4_ff  <= np4_in;
      end
   end

   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(4)) u_div_t1 (
      .clock, .reset, .en(eback), .num(nm4_ff), .den({c4_ff.a[DATA_W-1], c4_ff.a}),
      .sb_in({vb4_ff, neg4_ff, c4_ff.kind}), .quo(t1), .sb_out(d1_sb));
   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_t2 (
      .clock, .reset, .en(eback), .num(np4_ff), .den({c4_ff.a[DATA_W-1], c4_ff.a}),
      .sb_in(vb4_ff), .quo(t2), .sb_out(d2_v));
   rpi_div #(.FRAC_BITS(FRAC_BITS), .SW(1)) u_div_tl (
      .clock, .reset, .en(eback), .num(c4_ff.c), .den({c4_ff.b, 1'b0}),
      .sb_in(vb4_ff), .quo(tl), .sb_out(d3_v));

   assign out_v = d1_sb[3] && d2_v && d3_v;

   always_comb begin
      t_near_in = '0;
      t_far_in  = '0;
      hit_in    = 1'b0;
      status_in = ST_DEGEN;
      unique case (d1_sb[1:0])
         ST_DEGEN: begin
            status_in = ST_DEGEN;
         end
         ST_LINEAR: begin
            t_near_in = tl;
            t_far_in  = tl;
            hit_in    = 1'b1;
            status_in = ST_LINEAR;
         end
         default: begin
            if (d1_sb[2]) begin
               status_in = ST_NONE;
            end else begin
               t_near_in = t1;
               t_far_in  = t2;
               hit_in    = (!t1[DATA_W-1] && t1 != '0) && (!t2[DATA_W-1] && t2 != '0);
               status_in = ST_TWO;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eback) begin
         rsp_valid_ff <= out_v;
      end
   end

   always_ff @(posedge clock) begin
      if (eback) begin
         t_near_ff <= t_near_in;
         t_far_ff  <= t_far_in;
         hit_ff    <= hit_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign t_near      = t_near_ff;
   assign t_far       = t_far_ff;
   assign hit         = hit_ff;
   assign root_status = status_ff;

endmodule

// ----- rtl/core/ray_paraboloid_intersect_core.sv -----
// top level of the ray / paraboloid intersection core: configuration
// registers, front end, queue and back end; depends on rpi_pkg and all rpi_ modules
//
// One ray is accepted per clock unless a full queue holds the front end, and one
// result leaves per clock while the receiver is ready. The front end and the back
// end each hold bit-per-stage divider pipelines, and the back end also holds the
// root-bit-per-stage square root pipeline. A small queue between the coefficient
// front end and the root solver lets the front keep accepting rays while the result
// side is stalled, until the queue fills. The configuration port is always ready;
// write it only while no ray is in flight.
module ray_paraboloid_intersect_core import rpi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int QDEPTH    = QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [6*DATA_W-1:0]  req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // t_near, t_far
   output logic [2*DATA_W-1:0]  rsp_tdata,
   // hit, root_status
   output logic [2:0]           rsp_tuser,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);
   localparam logic [DATA_W-2:0] ONE_Q = (DATA_W-1)'(1) << FRAC_BITS;

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, queue_full, pop_valid, pop_ready;
   coef_type push_data, pop_data;
   logic signed [DATA_W-1:0] t_near, t_far;
   logic     hit;
   logic [1:0] root_status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_CENTER_X:   cfg_in.cx  = csr_data;
            REG_CENTER_Y:   cfg_in.cy  = csr_data;
            REG_CENTER_Z:   cfg_in.cz  = csr_data;
            REG_SEMI_A:     cfg_in.sa  = csr_data[DATA_W-2:0];
            REG_SEMI_B:     cfg_in.sb  = csr_data[DATA_W-2:0];
            REG_SEMI_C:     cfg_in.sc  = csr_data[DATA_W-2:0];
            REG_HYPERBOLIC: cfg_in.hyp = csr_data[0];
            default:        cfg_in     = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cx  <= '0;
         cfg_ff.cy  <= '0;
         cfg_ff.cz  <= '0;
         cfg_ff.sa  <= ONE_Q;
         cfg_ff.sb  <= ONE_Q;
         cfg_ff.sc  <= ONE_Q;
         cfg_ff.hyp <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .cfg(cfg_ff),
      .req_valid(req_tvalid), .req_ready(req_tready),
      .origin_x(req_tdata[0*DATA_W +: DATA_W]),
      .origin_y(req_tdata[1*DATA_W +: DATA_W]),
      .origin_z(req_tdata[2*DATA_W +: DATA_W]),
      .dir_x(req_tdata[3*DATA_W +: DATA_W]),
      .dir_y(req_tdata[4*DATA_W +: DATA_W]),
      .dir_z(req_tdata[5*DATA_W +: DATA_W]),
      .push_valid, .push_data, .queue_full);

   rpi_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock, .reset, .push_valid, .push_data, .full(queue_full),
      .pop_valid, .pop_data, .pop_ready);

   rpi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .pop_valid, .pop_data, .pop_ready,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .t_near, .t_far, .hit, .root_status);

   assign rsp_tdata = {t_far, t_near};
   assign rsp_tuser = {root_status, hit};

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && root_status == ST_DEGEN |-> t_near == '0 && t_far == '0 && !hit)
      else $error("degenerate beat with nonzero payload");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && root_status == ST_NONE |-> t_near == '0 && t_far == '0 && !hit)
      else $error("no-root beat with nonzero payload");

   a_linear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && root_status == ST_LINEAR |-> hit && t_near == t_far)
      else $error("linear beat without hit or with unequal distances");

   a_hit_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && root_status == ST_TWO && hit |-> t_near > 0 && t_far > 0)
      else $error("hit reported with a nonpositive root");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking bench for ray_paraboloid_intersect_core: random and directed rays
// against a fixed-point intersection predictor; depends on rpi_pkg and the core rtl
module tb_top;
   import rpi_pkg::*;

   typedef struct {
      logic signed [31:0] t_near;
      logic signed [31:0] t_far;
      logic               hit;
      logic [1:0]         status;
   } isect_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [191:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   ray_paraboloid_intersect_core uut (.*);

   // shadow of the configuration registers
   longint cen_x, cen_y, cen_z, ax_a, ax_b, ax_c;
   bit hyp;

   logic [191:0] ray_q[$];
   isect_t isect_q[$];
   int errors = 0;
   int hold_off = 0;
   int gap = 0;
   bit long_go = 0;
   bit long_hold = 0;

   initial forever #6 clock = ~clock;

   function automatic longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint fmul(longint a, longint b);
      longint p;
      p = a * b;
      return sat(p >>> 16);
   endfunction

   function automatic longint fdiv(longint n, longint d);
      return sat((n * 65536) / d);
   endfunction

   function automatic longint zs(longint v);
      return hyp ? sat(-v) : v;
   endfunction

   function automatic longint root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic isect_t predict_isect(logic [191:0] ray);
      isect_t res;
      longint ox, oy, oz, dx, dy, dz, dxa, dzc, pxa, pzc, ca, cb, cc, dl, s;
      ox = longint'($signed(ray[31:0]));
      oy = longint'($signed(ray[63:32]));
      oz = longint'($signed(ray[95:64]));
      dx = longint'($signed(ray[127:96]));
      dy = longint'($signed(ray[159:128]));
      dz = longint'($signed(ray[191:160]));
      res = '{0, 0, 0, ST_DEGEN};
      if (ax_a == 0 || ax_b == 0 || ax_c == 0) return res;
      dxa = fdiv(dx, ax_a);
      dzc = fdiv(dz, ax_c);
      pxa = fdiv(sat(ox - cen_x), ax_a);
      pzc = fdiv(sat(oz - cen_z), ax_c);
      ca = sat(fmul(dxa, dxa) + zs(fmul(dzc, dzc)));
      cb = sat(fmul(sat(-pxa), dxa) + zs(fmul(sat(-pzc), dzc)));
      cb = sat(cb + fdiv(dy, 2 * ax_b));
      cc = sat(fmul(pxa, pxa) + zs(fmul(pzc, pzc)));
      cc = sat(cc + fdiv(sat(cen_y - oy), ax_b));
      if (ca == 0) begin
         if (cb != 0) begin
            res.t_near = fdiv(cc, 2 * cb);
            res.t_far = res.t_near;
            res.hit = 1;
            res.status = ST_LINEAR;
         end
      end else begin
         dl = sat(fmul(cb, cb) - fmul(ca, cc));
         if (dl < 0) begin
            res.status = ST_NONE;
         end else begin
            s = root64(longint'(dl) << 16);
            res.t_near = fdiv(sat(cb - s), ca);
            res.t_far = fdiv(sat(cb + s), ca);
            res.hit = (res.t_near > 0 && res.t_far > 0);
            res.status = ST_TWO;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int pick_gap();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            isect_q.push_back(predict_isect(req_tdata));
            void'(ray_q.pop_front());
         end
         if (req_tvalid && !(req_tready)) begin
         end else if (gap > 0) begin
            gap <= gap - 1;
            req_tvalid <= 0;
         end else if ((req_tvalid && req_tready ? ray_q.size() > 0 : ray_q.size() > 0)) begin
            req_tvalid <= 1;
            req_tdata <= ray_q[0];
            if ($urandom_range(0, 2) == 0) gap <= pick_gap();
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      isect_t w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (isect_q.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               w = isect_q.pop_front();
               if ($signed(rsp_tdata[31:0]) != w.t_near)
                  report_mismatch("t_near", $signed(rsp_tdata[31:0]), w.t_near);
               if ($signed(rsp_tdata[63:32]) != w.t_far)
                  report_mismatch("t_far", $signed(rsp_tdata[63:32]), w.t_far);
               if (rsp_tuser[0] != w.hit) report_mismatch("hit", rsp_tuser[0], w.hit);
               if (rsp_tuser[2:1] != w.status)
                  report_mismatch("root_status", rsp_tuser[2:1], w.status);
            end
         end
         if (long_hold) begin
            rsp_tready <= 0;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 0;
            if ($urandom_range(0, 30) == 0) hold_off <= $urandom_range(5, 40);
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // long receiver stall so the input backs up
   initial begin
      wait (long_go);
      @(posedge clock);
      long_hold <= 1;
      repeat (400) @(posedge clock);
      long_hold <= 0;
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         REG_CENTER_X: cen_x = longint'($signed(val));
         REG_CENTER_Y: cen_y = longint'($signed(val));
         REG_CENTER_Z: cen_z = longint'($signed(val));
         REG_SEMI_A: ax_a = val[30:0];
         REG_SEMI_B: ax_b = val[30:0];
         REG_SEMI_C: ax_c = val[30:0];
         REG_HYPERBOLIC: hyp = val[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (ray_q.size() > 0 || req_tvalid || isect_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic logic [31:0] rnd_small();
      return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
   endfunction

   function automatic logic [31:0] rnd_field();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'h0;
         default: return rnd_small();
      endcase
   endfunction

   task automatic push_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
      ray_q.push_back({dz, dy, dx, oz, oy, ox});
   endtask

   task automatic random_rays(int n);
      logic [31:0] f[6];
      repeat (n) begin
         foreach (f[i]) f[i] = rnd_field();
         push_ray(f[0], f[1], f[2], f[3], f[4], f[5]);
      end
   endtask

   task automatic random_config();
      write_reg(REG_CENTER_X, rnd_field());
      write_reg(REG_CENTER_Y, rnd_field());
      write_reg(REG_CENTER_Z, rnd_field());
      write_reg(REG_SEMI_A, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1 << 14, 4 << 16));
      write_reg(REG_SEMI_B, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1 << 14, 4 << 16));
      write_reg(REG_SEMI_C, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1 << 14, 4 << 16));
      write_reg(REG_HYPERBOLIC, $urandom_range(0, 1));
   endtask

   initial begin
      cen_x = 0; cen_y = 0; cen_z = 0;
      ax_a = 65536; ax_b = 65536; ax_c = 65536;
      hyp = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed: linear, two roots, no roots, zero b, extremes
      push_ray(0, 32'hfffe_0000, 0, 0, 32'h0001_0000, 0);
      push_ray(0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0);
      push_ray(0, 32'hfffb_0000, 0, 32'h0001_0000, 0, 0);
      push_ray(0, 0, 0, 0, 0, 0);
      push_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      push_ray(32'h0003_0000, 0, 32'hfffe_0000, 32'hffff_0000, 32'h0000_8000, 32'h0001_0000);
      drain();
      write_reg(REG_HYPERBOLIC, 1);
      push_ray(0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000);
      push_ray(0, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 0, 32'h0000_8000);
      random_rays(6);
      drain();
      write_reg(REG_SEMI_A, 0);
      push_ray(0, 0, 0, 32'h0001_0000, 0, 0);
      drain();
      write_reg(REG_SEMI_A, 32'h7fff_ffff);
      write_reg(REG_SEMI_B, 1);
      write_reg(REG_SEMI_C, 32'h7fff_ffff);
      write_reg(REG_CENTER_X, 32'h8000_0000);
      write_reg(REG_CENTER_Y, 32'h7fff_ffff);
      write_reg(REG_CENTER_Z, 32'h8000_0000);
      random_rays(6);
      drain();
      for (int b = 0; b < 11; b++) begin
         random_config();
         if (b == 5) long_go = 1;
         random_rays(100);
         drain();
      end
      if (errors == 0) $display("ray_paraboloid_intersect_core test passed");
      else $display("ray_paraboloid_intersect_core test failed");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("ray_paraboloid_intersect_core test failed");
      $finish;
   end
endmodule
